@@ hdl/ipcd_pkg.sv @@
// Shared types and constants for the IR pulse command decoder.
// No dependencies; used by ir_pulse_command_decoder_unit.
`default_nettype none

package ipcd_pkg;

  // Item commands
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_PAUSE = 2'd2,
    OP_GET   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_WINDOW = 3'd0;
  localparam logic [2:0] REG_LATER_WINDOW = 3'd1;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH    = 3'd3;
  localparam logic [2:0] REG_ONE_LOW      = 3'd4;
  localparam logic [2:0] REG_ONE_HIGH     = 3'd5;

  // Register reset values
  localparam logic [15:0] FIRST_WINDOW_RST = 16'd30000;
  localparam logic [15:0] LATER_WINDOW_RST = 16'd10000;
  localparam logic [14:0] ZERO_LOW_RST     = 15'd1000;
  localparam logic [14:0] ZERO_HIGH_RST    = 15'd1300;
  localparam logic [14:0] ONE_LOW_RST      = 15'd2000;
  localparam logic [14:0] ONE_HIGH_RST     = 15'd2500;

  // Frame layout: intervals per valid frame and the first command-bit interval
  localparam logic [5:0] FRAME_EDGES     = 6'd33;
  localparam logic [5:0] FIRST_BIT_INDEX = 6'd17;
  localparam logic [5:0] LAST_BIT_INDEX  = FIRST_BIT_INDEX + 6'd7;
  localparam logic [5:0] EDGE_COUNT_MAX  = 6'd63;
  localparam logic [15:0] TICK_COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

@@ hdl/ir_pulse_command_decoder_unit.sv @@
// IR pulse command decoder top level: input register, frame decode state, result register.
// Depends on ipcd_pkg for commands, register indexes and frame constants.
`default_nettype none

// Takes one item per clock: a timer tick (two ticks per microsecond) with an
// optional falling-edge flag, or a start, pause or get command. Every item
// gives exactly one result (key, ready_res) via the input register and then the
// result register. The sustained rate is one item per cycle when the output is
// not stalled; the decode state is updated from the registered item as the result
// is captured, so consecutive items chain without bubbles. A stall on the output
// holds the result register and then the input register, and only then stalls input.
module ir_pulse_command_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic        edge_req,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       key,
  output logic             ready_res,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] first_window;
  logic [15:0] later_window;
  logic [14:0] zero_low;
  logic [14:0] zero_high;
  logic [14:0] one_low;
  logic [14:0] one_high;

  // Decode state
  logic        enabled,        enabled_next;
  logic        in_frame,       in_frame_next;
  logic [5:0]  edge_count,     edge_count_next;
  logic [15:0] tick_count,     tick_count_next;
  logic        window_is_long, window_is_long_next;
  logic [7:0]  set_mask,       set_mask_next;
  logic [7:0]  clear_mask,     clear_mask_next;
  logic [7:0]  code_byte,      code_byte_next;
  logic        ready_flag,     ready_flag_next;
  logic [7:0]  key_next;

  // Input register
  logic          s1_valid;
  ipcd_pkg::op_t s1_op;
  logic          s1_edge;

  logic out_adv;
  logic s1_fire;

  // Advance the result register when empty or taken
  assign out_adv  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_adv;
  assign in_stall = s1_valid && !out_adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_window <= ipcd_pkg::FIRST_WINDOW_RST;
      later_window <= ipcd_pkg::LATER_WINDOW_RST;
      zero_low     <= ipcd_pkg::ZERO_LOW_RST;
      zero_high    <= ipcd_pkg::ZERO_HIGH_RST;
      one_low      <= ipcd_pkg::ONE_LOW_RST;
      one_high     <= ipcd_pkg::ONE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipcd_pkg::REG_FIRST_WINDOW: first_window <= cfg_data;
        ipcd_pkg::REG_LATER_WINDOW: later_window <= cfg_data;
        ipcd_pkg::REG_ZERO_LOW:     zero_low     <= cfg_data[14:0];
        ipcd_pkg::REG_ZERO_HIGH:    zero_high    <= cfg_data[14:0];
        ipcd_pkg::REG_ONE_LOW:      one_low      <= cfg_data[14:0];
        ipcd_pkg::REG_ONE_HIGH:     one_high     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= ipcd_pkg::op_t'(op);
      s1_edge <= edge_req;
    end
  end

  // Decode one item against the current state
  always_comb begin
    logic [14:0] interval;
    logic [5:0]  bit_offset;
    logic [7:0]  bit_sel;
    logic [15:0] window;
    logic        in_cmd_range;
    logic        is_zero;
    logic        is_one;

    enabled_next        = enabled;
    in_frame_next       = in_frame;
    edge_count_next     = edge_count;
    tick_count_next     = tick_count;
    window_is_long_next = window_is_long;
    set_mask_next       = set_mask;
    clear_mask_next     = clear_mask;
    code_byte_next      = code_byte;
    ready_flag_next     = ready_flag;
    key_next            = 8'd0;

    // Advance the interval counter first, then classify against it
    if (in_frame && tick_count != ipcd_pkg::TICK_COUNT_MAX) begin
      tick_count_next = tick_count + 16'd1;
    end

    interval     = tick_count_next[15:1];
    bit_offset   = edge_count - ipcd_pkg::FIRST_BIT_INDEX;
    bit_sel      = 8'd1 << bit_offset[2:0];
    in_cmd_range = (edge_count >= ipcd_pkg::FIRST_BIT_INDEX) &&
                   (edge_count <= ipcd_pkg::LAST_BIT_INDEX);
    is_zero      = (interval > zero_low) && (interval < zero_high);
    is_one       = (interval > one_low) && (interval < one_high);
    window       = window_is_long ? first_window : later_window;

    unique case (s1_op)
      ipcd_pkg::OP_TICK: begin
        if (s1_edge && enabled) begin
          if (!in_frame) begin
            // Open a frame with the long window
            in_frame_next       = 1'b1;
            window_is_long_next = 1'b1;
            edge_count_next     = 6'd0;
            tick_count_next     = 16'd0;
            set_mask_next       = 8'd0;
            clear_mask_next     = 8'd0;
          end else begin
            // Classify a command interval, then re-arm the short window
            if (in_cmd_range) begin
              if (is_zero) begin
                clear_mask_next = clear_mask | bit_sel;
                set_mask_next   = set_mask & ~bit_sel;
              end else if (is_one) begin
                set_mask_next   = set_mask | bit_sel;
                clear_mask_next = clear_mask & ~bit_sel;
              end
            end
            if (edge_count != ipcd_pkg::EDGE_COUNT_MAX) begin
              edge_count_next = edge_count + 6'd1;
            end
            tick_count_next     = 16'd0;
            window_is_long_next = 1'b0;
          end
        end else if (in_frame && tick_count_next >= window) begin
          // Window ran out: commit only a full-length frame, then close
          if (edge_count == ipcd_pkg::FRAME_EDGES) begin
            code_byte_next  = (code_byte & ~clear_mask) | set_mask;
            ready_flag_next = 1'b1;
          end
          in_frame_next       = 1'b0;
          edge_count_next     = 6'd0;
          tick_count_next     = 16'd0;
          window_is_long_next = 1'b0;
          set_mask_next       = 8'd0;
          clear_mask_next     = 8'd0;
        end
      end
      ipcd_pkg::OP_START: begin
        tick_count_next = tick_count;
        code_byte_next  = 8'd0;
        ready_flag_next = 1'b0;
        enabled_next    = 1'b1;
      end
      ipcd_pkg::OP_PAUSE: begin
        enabled_next        = 1'b0;
        in_frame_next       = 1'b0;
        edge_count_next     = 6'd0;
        tick_count_next     = 16'd0;
        window_is_long_next = 1'b0;
        set_mask_next       = 8'd0;
        clear_mask_next     = 8'd0;
      end
      ipcd_pkg::OP_GET: begin
        tick_count_next = tick_count;
        // Hand out a ready, nonzero byte once
        if (ready_flag && code_byte != 8'd0) begin
          key_next        = code_byte;
          code_byte_next  = 8'd0;
          ready_flag_next = 1'b0;
          set_mask_next   = 8'd0;
          clear_mask_next = 8'd0;
        end
      end
      default: begin
        tick_count_next = tick_count;
      end
    endcase
  end

  // Update decode state when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      in_frame       <= 1'b0;
      edge_count     <= 6'd0;
      tick_count     <= 16'd0;
      window_is_long <= 1'b0;
      set_mask       <= 8'd0;
      clear_mask     <= 8'd0;
      code_byte      <= 8'd0;
      ready_flag     <= 1'b0;
    end else if (s1_fire) begin
      enabled        <= enabled_next;
      in_frame       <= in_frame_next;
      edge_count     <= edge_count_next;
      tick_count     <= tick_count_next;
      window_is_long <= window_is_long_next;
      set_mask       <= set_mask_next;
      clear_mask     <= clear_mask_next;
      code_byte      <= code_byte_next;
      ready_flag     <= ready_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      key       <= key_next;
      ready_res <= ready_flag_next;
    end
  end

endmodule

`default_nettype wire
